>>> rtl/ssq_pkg.sv
// Shared types, constants and helper functions for the sensor sample qualifier.
// Used by every module of the block; it has no dependencies of its own.

package ssq_pkg;

  // Sequence phases, in the encoding that the phase output shows
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_READY  = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_FINISH = 2'd3
  } phase_t;

  // Configuration register index (word address)
  typedef enum logic [1:0] {
    REG_TEMP_OFFSET = 2'd0,
    REG_HUMI_OFFSET = 2'd1,
    REG_COMP_ENABLE = 2'd2
  } reg_idx_t;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Default parameter values
  localparam int DEF_REFRESH_TICKS = 10;
  localparam int DEF_RETRY_LIMIT   = 3;

  // Valid windows, tenths of a unit
  localparam logic signed [15:0] TEMP_LOW  = -16'sd200;
  localparam logic signed [15:0] TEMP_HIGH = 16'sd1500;
  localparam logic signed [15:0] HUMI_HIGH = 16'sd1000;
  localparam logic [4:0]         SELF_HEAT = 5'd20;
  localparam logic [3:0]         RETRY_MAX = 4'hf;

  typedef struct packed {
    logic signed [15:0] temp_offset;
    logic signed [15:0] humi_offset;
    logic               comp_enable;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic               acq_error;
    logic signed [15:0] raw_temp;
    logic signed [15:0] raw_humi;
    logic [2:0]         backlight_level;
  } item_t;

  typedef struct packed {
    logic signed [15:0] temp_value;
    logic signed [15:0] humi_value;
    logic               temp_fault;
    logic               humi_fault;
    phase_t             phase;
    logic               sensor_power;
    logic               reading_used;
    logic               cycle_done;
  } result_t;

  // Self-heating correction: fixed part plus backlight-dependent part
  function automatic logic [4:0] comp_amount(input logic [2:0] level);
    logic [4:0] extra;
    case (level)
      3'd1:    extra = 5'd0;
      3'd2:    extra = 5'd2;
      3'd3:    extra = 5'd5;
      3'd4:    extra = 5'd8;
      default: extra = 5'd10;
    endcase
    return SELF_HEAT + extra;
  endfunction

endpackage

>>> rtl/ssq_cfg.sv
// APB-style configuration registers: offsets and compensation enable.
// Depends on ssq_pkg for the register index codes and cfg_t.

module ssq_cfg
  import ssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_offset <= '0;
      cfg.humi_offset <= '0;
      cfg.comp_enable <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_TEMP_OFFSET: cfg.temp_offset <= pwdata[15:0];
        REG_HUMI_OFFSET: cfg.humi_offset <= pwdata[15:0];
        REG_COMP_ENABLE: cfg.comp_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux, offsets sign-extended
  always_comb begin
    unique case (idx)
      REG_TEMP_OFFSET: prdata = DATA_W'(cfg.temp_offset);
      REG_HUMI_OFFSET: prdata = DATA_W'(cfg.humi_offset);
      REG_COMP_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg.comp_enable};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/ssq_core.sv
// Sequence state, refresh countdown, retry counter and the one-step
// qualification datapath. Depends on ssq_pkg.

module ssq_core
  import ssq_pkg::*;
#(
  parameter int REFRESH_TICKS = DEF_REFRESH_TICKS,
  parameter int RETRY_LIMIT   = DEF_RETRY_LIMIT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t             seq_phase, seq_phase_next, phase_run;
  logic [15:0]        refresh_count, refresh_count_next;
  logic [3:0]         retry_count, retry_count_next, retry_bump;
  logic signed [15:0] held_temp, held_temp_next;
  logic signed [15:0] held_humi, held_humi_next;
  logic               temp_fault_flag, temp_fault_flag_next;
  logic               humi_fault_flag, humi_fault_flag_next;

  logic               reload;
  logic signed [15:0] temp_comp, temp_adj, humi_adj;
  logic               temp_ok, humi_pos, humi_ok, at_limit;
  logic               used, done;

  // Refresh countdown: restart the sequence when it runs out
  assign reload = (refresh_count <= 16'd1);

  always_comb begin
    if (item.action)     refresh_count_next = refresh_count;
    else if (reload)     refresh_count_next = 16'(REFRESH_TICKS);
    else                 refresh_count_next = refresh_count - 16'd1;
  end

  assign phase_run = reload ? PH_READY : seq_phase;

  // Next phase
  always_comb begin
    if (item.action) begin
      seq_phase_next = PH_READY;
    end else begin
      unique case (phase_run)
        PH_READY:  seq_phase_next = PH_ACTIVE;
        PH_ACTIVE: seq_phase_next = PH_FINISH;
        PH_FINISH: seq_phase_next = PH_IDLE;
        default:   seq_phase_next = PH_IDLE;
      endcase
    end
  end

  // Reading path: compensation, offsets, window checks (16-bit wrap)
  assign temp_comp = cfg.comp_enable
                   ? item.raw_temp - $signed({11'b0, comp_amount(item.backlight_level)})
                   : item.raw_temp;
  assign temp_adj  = temp_comp + cfg.temp_offset;
  assign humi_adj  = item.raw_humi + cfg.humi_offset;
  assign temp_ok   = (temp_adj >= TEMP_LOW) && (temp_adj < TEMP_HIGH);
  assign humi_pos  = (humi_adj > 16'sd0);
  assign humi_ok   = humi_pos && (humi_adj < HUMI_HIGH);

  assign retry_bump = (temp_ok && humi_pos) ? 4'd0
                    : (retry_count < RETRY_MAX) ? retry_count + 4'd1 : retry_count;
  assign at_limit   = (retry_bump >= 4'(RETRY_LIMIT));

  // Phase outputs and held values
  always_comb begin
    retry_count_next     = retry_count;
    held_temp_next       = held_temp;
    held_humi_next       = held_humi;
    temp_fault_flag_next = temp_fault_flag;
    humi_fault_flag_next = humi_fault_flag;
    used                 = 1'b0;
    done                 = 1'b0;
    if (!item.action) begin
      unique case (phase_run)
        PH_READY: retry_count_next = '0;
        PH_ACTIVE: begin
          used = 1'b1;
          if (item.acq_error) begin
            held_temp_next       = '0;
            held_humi_next       = '0;
            temp_fault_flag_next = 1'b1;
            humi_fault_flag_next = 1'b1;
          end else begin
            retry_count_next = retry_bump;
            if (temp_ok) begin
              held_temp_next       = temp_adj;
              temp_fault_flag_next = 1'b0;
            end else if (at_limit) begin
              held_temp_next       = '0;
              temp_fault_flag_next = 1'b1;
            end
            if (humi_ok) begin
              held_humi_next       = humi_adj;
              humi_fault_flag_next = 1'b0;
            end else if (at_limit) begin
              held_humi_next       = '0;
              humi_fault_flag_next = 1'b1;
            end
          end
        end
        PH_FINISH: done = 1'b1;
        default: ;
      endcase
    end
  end

  // State update, one item per step
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase       <= PH_READY;
      refresh_count   <= 16'd1;
      retry_count     <= '0;
      held_temp       <= '0;
      held_humi       <= '0;
      temp_fault_flag <= 1'b0;
      humi_fault_flag <= 1'b0;
    end else if (step) begin
      seq_phase       <= seq_phase_next;
      refresh_count   <= refresh_count_next;
      retry_count     <= retry_count_next;
      held_temp       <= held_temp_next;
      held_humi       <= held_humi_next;
      temp_fault_flag <= temp_fault_flag_next;
      humi_fault_flag <= humi_fault_flag_next;
    end
  end

  // Result after this step
  assign res.temp_value   = held_temp_next;
  assign res.humi_value   = held_humi_next;
  assign res.temp_fault   = temp_fault_flag_next;
  assign res.humi_fault   = humi_fault_flag_next;
  assign res.phase        = seq_phase_next;
  assign res.sensor_power = (seq_phase_next != PH_IDLE);
  assign res.reading_used = used;
  assign res.cycle_done   = done;

endmodule

>>> rtl/sensor_sample_qualifier.sv
// Top level of the sensor sample qualifier: input register, step core,
// result register and configuration port. Depends on ssq_pkg, ssq_cfg, ssq_core.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one tick or trigger per transfer
//   with the reading fields. Output channel (out_valid/out_stall) returns one
//   result per input transfer, in order: held values, fault flags, phase and
//   per-step status bits.
//   Path: the input transfer loads the input register; when the result register
//   is free, the step result moves into it and out_valid rises, so a receiver
//   stall can hold an item in the input register between the two.
//   Throughput is one item per cycle while the receiver does not stall; the
//   single-pass step between the input and result registers sets it.
//   While the receiver stalls, the result register holds and the input
//   register still takes one more item; in_stall rises only when both are full.
//   Reset (rst, synchronous) empties both registers, sets the phase to ready,
//   the refresh countdown to 1 and clears retry count, held values and flags.
//   The user writes configuration over the APB-style port only while the
//   block is idle (not enforced); after reset compensation is on, offsets zero.

module sensor_sample_qualifier
  import ssq_pkg::*;
#(
  parameter int REFRESH_TICKS = DEF_REFRESH_TICKS,
  parameter int RETRY_LIMIT   = DEF_RETRY_LIMIT
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               acq_error,
  input  logic signed [15:0] raw_temp,
  input  logic signed [15:0] raw_humi,
  input  logic [2:0]         backlight_level,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temp_value,
  output logic signed [15:0] humi_value,
  output logic               temp_fault,
  output logic               humi_fault,
  output logic [1:0]         phase,
  output logic               sensor_power,
  output logic               reading_used,
  output logic               cycle_done
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t step_res, out_res;

  ssq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage handshake: item moves on when the result register is free
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.action          <= action;
      s1_item.acq_error       <= acq_error;
      s1_item.raw_temp        <= raw_temp;
      s1_item.raw_humi        <= raw_humi;
      s1_item.backlight_level <= backlight_level;
    end
  end

  ssq_core #(
    .REFRESH_TICKS (REFRESH_TICKS),
    .RETRY_LIMIT   (RETRY_LIMIT)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign temp_value   = out_res.temp_value;
  assign humi_value   = out_res.humi_value;
  assign temp_fault   = out_res.temp_fault;
  assign humi_fault   = out_res.humi_fault;
  assign phase        = out_res.phase;
  assign sensor_power = out_res.sensor_power;
  assign reading_used = out_res.reading_used;
  assign cycle_done   = out_res.cycle_done;

endmodule

>>> rtl/ssq_checker.sv
// Port-level checks for the sensor sample qualifier, bound to the top level.
// Depends on ssq_pkg for the phase codes.

module ssq_checker
  import ssq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] temp_value,
  input logic [1:0]         phase,
  input logic               sensor_power,
  input logic               reading_used,
  input logic               cycle_done
);

  // Stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temp_value) && $stable(phase))
    else $error("result changed while stalled");

  // Power follows phase
  a_power: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sensor_power == (phase != PH_IDLE)))
    else $error("sensor_power disagrees with phase");

  // A reading step always leaves the sequence in finish
  a_used_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && reading_used |-> (phase == PH_FINISH) && !cycle_done)
    else $error("reading step did not end in finish");

  // A finish step always leaves the sequence idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && cycle_done |-> (phase == PH_IDLE) && !sensor_power)
    else $error("finish step did not end idle");

endmodule

bind sensor_sample_qualifier ssq_checker u_ssq_checker (.*);

>>> tb/sv/sensor_sample_qualifier_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_sample_qualifier: scoreboard class with its own
// step predictor, tasks that drive the input and APB-style ports, and an output checker.
// Depends on ssq_pkg and the sensor_sample_qualifier RTL.

import ssq_pkg::*;

// Predicts each step of the qualifier and checks the results in transfer order
class ssq_scoreboard;
  // configuration copy
  logic signed [15:0] t_off;
  logic signed [15:0] h_off;
  logic               comp_on;
  // sequence state copy
  phase_t             seq;
  logic [15:0]        countdown;
  logic [3:0]         retries;
  logic signed [15:0] hold_t;
  logic signed [15:0] hold_h;
  logic               flag_t;
  logic               flag_h;

  result_t            expected_q[$];
  int                 errors;
  int                 results_seen;
  int                 readings;
  int                 failed_reads;
  int                 done_cycles;
  int                 triggers;

  function new();
    t_off     = '0;
    h_off     = '0;
    comp_on   = 1'b1;
    seq       = PH_READY;
    countdown = 16'd1;
    retries   = '0;
    hold_t    = '0;
    hold_h    = '0;
    flag_t    = 1'b0;
    flag_h    = 1'b0;
    errors    = 0;
    results_seen = 0;
    readings  = 0;
    failed_reads = 0;
    done_cycles = 0;
    triggers  = 0;
  endfunction

  // Self-heating drop: 20 plus the backlight share
  static function logic [15:0] heat_drop(logic [2:0] level);
    case (level)
      3'd1:    return 16'd20;
      3'd2:    return 16'd22;
      3'd3:    return 16'd25;
      3'd4:    return 16'd28;
      default: return 16'd30;
    endcase
  endfunction

  function void write_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_TEMP_OFFSET: t_off = v[15:0];
      REG_HUMI_OFFSET: h_off = v[15:0];
      REG_COMP_ENABLE: comp_on = v[0];
      default: ;
    endcase
  endfunction

  // Active phase: qualify one reading
  function void take_reading(item_t it);
    logic signed [15:0] t;
    logic signed [15:0] h;
    logic               t_ok;
    logic               h_ok;
    readings++;
    if (it.acq_error) begin
      failed_reads++;
      flag_t = 1'b1;
      flag_h = 1'b1;
      hold_t = '0;
      hold_h = '0;
      return;
    end
    t = it.raw_temp;
    if (comp_on)
      t = t - heat_drop(it.backlight_level);
    t = t + t_off;
    h = it.raw_humi + h_off;
    t_ok = (t >= TEMP_LOW) && (t < TEMP_HIGH);
    h_ok = (h > 16'sd0) && (h < HUMI_HIGH);
    if (t_ok) begin
      hold_t = t;
      flag_t = 1'b0;
    end
    if (h_ok) begin
      hold_h = h;
      flag_h = 1'b0;
    end
    // retry counter saturates at all ones
    if (t_ok && h > 16'sd0)
      retries = '0;
    else if (retries != RETRY_MAX)
      retries++;
    if (retries >= DEF_RETRY_LIMIT) begin
      if (!t_ok) begin
        flag_t = 1'b1;
        hold_t = '0;
      end
      if (!h_ok) begin
        flag_h = 1'b1;
        hold_h = '0;
      end
    end
  endfunction

  // Note an accepted input transfer and queue the result it causes
  function void note_input(item_t it);
    result_t r;
    logic    used;
    logic    done;
    used = 1'b0;
    done = 1'b0;
    if (it.action) begin
      triggers++;
      seq = PH_READY;
    end else begin
      if (countdown <= 16'd1) begin
        seq = PH_READY;
        countdown = 16'(DEF_REFRESH_TICKS);
      end else begin
        countdown--;
      end
      case (seq)
        PH_READY: begin
          retries = '0;
          seq = PH_ACTIVE;
        end
        PH_ACTIVE: begin
          take_reading(it);
          used = 1'b1;
          seq = PH_FINISH;
        end
        PH_FINISH: begin
          done = 1'b1;
          done_cycles++;
          seq = PH_IDLE;
        end
        default: ;
      endcase
    end
    r.temp_value   = hold_t;
    r.humi_value   = hold_h;
    r.temp_fault   = flag_t;
    r.humi_fault   = flag_h;
    r.phase        = seq;
    r.sensor_power = (seq != PH_IDLE);
    r.reading_used = used;
    r.cycle_done   = done;
    expected_q.push_back(r);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    if (errors < 100)
      $display("ERROR: %s", msg);
    errors++;
  endtask

  task cmp_field(string name, int got, int want);
    if (got != want)
      report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want));
  endtask

  // Check one accepted result against the oldest expectation
  task check_result(result_t got);
    result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = expected_q.pop_front();
    cmp_field("temp_value", got.temp_value, want.temp_value);
    cmp_field("humi_value", got.humi_value, want.humi_value);
    cmp_field("temp_fault", got.temp_fault, want.temp_fault);
    cmp_field("humi_fault", got.humi_fault, want.humi_fault);
    cmp_field("phase", got.phase, want.phase);
    cmp_field("sensor_power", got.sensor_power, want.sensor_power);
    cmp_field("reading_used", got.reading_used, want.reading_used);
    cmp_field("cycle_done", got.cycle_done, want.cycle_done);
  endtask

  task close_out();
    if (expected_q.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_q.size()));
  endtask
endclass

module sensor_sample_qualifier_test;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = 1'b0;
  logic               acq_error = 1'b0;
  logic signed [15:0] raw_temp = '0;
  logic signed [15:0] raw_humi = '0;
  logic [2:0]         backlight_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] temp_value;
  logic signed [15:0] humi_value;
  logic               temp_fault;
  logic               humi_fault;
  logic [1:0]         phase;
  logic               sensor_power;
  logic               reading_used;
  logic               cycle_done;

  int sender_idle_pct = 6;
  int recv_stall_pct  = 55;
  int sent = 0;
  int temp_edges[4] = '{-201, -200, 1499, 1500};
  int humi_edges[6] = '{-1, 0, 1, 999, 1000, 1001};

  ssq_scoreboard sb = new();

  sensor_sample_qualifier u_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .acq_error       (acq_error),
    .raw_temp        (raw_temp),
    .raw_humi        (raw_humi),
    .backlight_level (backlight_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .temp_value      (temp_value),
    .humi_value      (humi_value),
    .temp_fault      (temp_fault),
    .humi_fault      (humi_fault),
    .phase           (phase),
    .sensor_power    (sensor_power),
    .reading_used    (reading_used),
    .cycle_done      (cycle_done)
  );

  always #2 clk = ~clk;

  // Output side: random stall, check each result transfer
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got.temp_value   = temp_value;
      got.humi_value   = humi_value;
      got.temp_fault   = temp_fault;
      got.humi_fault   = humi_fault;
      got.phase        = phase_t'(phase);
      got.sensor_power = sensor_power;
      got.reading_used = reading_used;
      got.cycle_done   = cycle_done;
      sb.check_result(got);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // One input transfer; valid stays high afterwards unless the next call idles
  task automatic send(item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= it.action;
    acq_error       <= it.acq_error;
    raw_temp        <= it.raw_temp;
    raw_humi        <= it.raw_humi;
    backlight_level <= it.backlight_level;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  // Let the block run dry, then idle while the input and result registers empty
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Setup phase, access phase, then the bus returns to idle
  task automatic apb_write(reg_idx_t idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Trigger, tick into active, then the tick that takes the reading
  task automatic directed_reading(logic err, logic signed [15:0] rt, logic signed [15:0] rh,
                                  logic [2:0] bl);
    item_t it;
    it.action          = 1'b1;
    it.acq_error       = 1'b0;
    it.raw_temp        = rt;
    it.raw_humi        = rh;
    it.backlight_level = bl;
    send(it);
    it.action = 1'b0;
    send(it);
    it.acq_error = err;
    send(it);
  endtask

  // Random item; readings mostly land near the windows after compensation and offsets
  function automatic item_t make_item(logic act);
    item_t it;
    int    sel;
    int    t_target;
    int    h_target;
    it.action          = act;
    it.acq_error       = ($urandom_range(99) < 8);
    it.backlight_level = 3'($urandom_range(7));
    sel = $urandom_range(99);
    if (sel < 20) begin
      it.raw_temp = 16'($urandom_range(16'hffff));
      it.raw_humi = 16'($urandom_range(16'hffff));
    end else begin
      if (sel < 35) begin
        t_target = temp_edges[$urandom_range(3)];
        h_target = humi_edges[$urandom_range(5)];
      end else begin
        t_target = int'($urandom_range(2100)) - 400;
        h_target = int'($urandom_range(1300)) - 150;
      end
      it.raw_temp = 16'(t_target) - sb.t_off;
      if (sb.comp_on)
        it.raw_temp = it.raw_temp + sb.heat_drop(it.backlight_level);
      it.raw_humi = 16'(h_target) - sb.h_off;
    end
    return it;
  endfunction

  initial begin
    logic signed [15:0] t_set;
    logic signed [15:0] h_set;
    logic               c_set;
    int                 n;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: window edges, every backlight level, failed acquisition, field extremes
    directed_reading(1'b0, 16'sd270, 16'sd450, 3'd1);
    directed_reading(1'b0, -16'sd178, 16'sd1, 3'd2);
    directed_reading(1'b0, -16'sd176, 16'sd0, 3'd3);
    directed_reading(1'b0, 16'sd1527, 16'sd999, 3'd4);
    directed_reading(1'b0, 16'sd1530, 16'sd1000, 3'd5);
    directed_reading(1'b1, 16'sd130, 16'sd100, 3'd6);
    directed_reading(1'b0, 16'sh7fff, 16'sh8000, 3'd7);
    directed_reading(1'b0, 16'sh8000, 16'sh7fff, 3'd0);
    send(make_item(1'b0));

    // Random phases, each under its own configuration; idle and stall patterns change every two phases
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin t_set = 16'sh8000; h_set = 16'sh7fff; c_set = 1'b0; end
        1: begin t_set = 16'sh7fff; h_set = 16'sh8000; c_set = 1'b1; end
        2: begin
          t_set = 16'(int'($urandom_range(600)) - 300);
          h_set = 16'(int'($urandom_range(600)) - 300);
          c_set = 1'b0;
        end
        3: begin
          t_set = 16'($urandom_range(16'hffff));
          h_set = 16'($urandom_range(16'hffff));
          c_set = 1'b1;
        end
        4: begin t_set = '0; h_set = '0; c_set = 1'b0; end
        default: begin
          t_set = 16'(int'($urandom_range(600)) - 300);
          h_set = 16'(int'($urandom_range(600)) - 300);
          c_set = 1'b1;
        end
      endcase
      sender_idle_pct = (p < 2) ? 6 : (p < 4) ? 55 : 0;
      recv_stall_pct  = (p < 2) ? 55 : (p < 4) ? 6 : 0;
      apb_write(REG_TEMP_OFFSET, {{16{t_set[15]}}, t_set});
      apb_write(REG_HUMI_OFFSET, {{16{h_set[15]}}, h_set});
      apb_write(REG_COMP_ENABLE, {31'd0, c_set});

      n = 0;
      while (n < 171) begin
        if ($urandom_range(99) < 30) begin
          send(make_item(1'b1));
          send(make_item(1'b0));
          send(make_item(1'b0));
          n += 3;
        end else begin
          send(make_item($urandom_range(99) < 5));
          n++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    sb.close_out();
    $display("Run covered %0d transfers and %0d results under 7 register settings.",
             sent, sb.results_seen);
    $display("Readings taken: %0d (%0d failed), sequences finished: %0d, triggers: %0d.",
             sb.readings, sb.failed_reads, sb.done_cycles, sb.triggers);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("Mismatches found");
    $finish;
  end

endmodule
